@@ rtl/first_fit_heap_allocator_with_gc_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_WITH_GC_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_WITH_GC_UNIT_DEFINES_SVH

// Hold a condition at every clock edge outside reset.
`define FFHA_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Require a consequence in the cycle after an antecedent.
`define FFHA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int CHUNK_SLOTS  = 32;
  localparam int ROOT_SLOTS   = 32;
  localparam int CIX_W        = $clog2(CHUNK_SLOTS);
  localparam int RIX_W        = $clog2(ROOT_SLOTS);

  localparam logic [2:0] K_INIT    = 3'd0;
  localparam logic [2:0] K_ALLOC   = 3'd1;
  localparam logic [2:0] K_FREE    = 3'd2;
  localparam logic [2:0] K_ROOT    = 3'd3;
  localparam logic [2:0] K_COLLECT = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ARG    = 3'd1;
  localparam logic [2:0] ST_NO_MEM     = 3'd2;
  localparam logic [2:0] ST_TOO_MANY   = 3'd3;
  localparam logic [2:0] ST_BUSY       = 3'd4;
  localparam logic [2:0] ST_BAD_PTR    = 3'd5;
  localparam logic [2:0] ST_ROOTS_FULL = 3'd6;
endpackage
`default_nettype wire

@@ rtl/first_fit_heap_allocator_with_gc_unit.sv @@
// First-fit heap allocator with coalescing and mark-and-sweep collection.
// One command is taken at a time and gives one result. The chunk table
// (start, size, in-use, mark) is read through one index per cycle; a
// small sequencer drives that port and one shared add/compare path.
// Steps after the input transfer: init, register root and any command
// rejected at dispatch finish from dispatch; a free of a chunk that is
// already free stops after the drop step; alloc walks the chunks first-fit
// until one fits or the table ends; free releases the chunk, then runs the
// coalescing walk; collect marks one root per step (each root is matched
// against all chunks at once), sweeps each chunk, then runs the coalescing
// walk.
// in_ready is high only while no command is in flight; a finished result
// sits in the output register until transferred and does not block the
// next input transfer. Registers: heap_bytes at 0x0, alloc_limit at 0x4.
`default_nettype none
module first_fit_heap_allocator_with_gc_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [12:0] request_bytes,
  input  wire logic [11:0] block_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [11:0]      payload_offset,
  output logic [12:0]      avail_bytes,
  output logic [3:0]       live_count,
  output logic [3:0]       swept_count
);
  localparam int NC = ffha_pkg::CHUNK_SLOTS;
  localparam int NR = ffha_pkg::ROOT_SLOTS;
  localparam int CW = ffha_pkg::CIX_W;
  localparam int RW = ffha_pkg::RIX_W;
  localparam logic [12:0] HDR = 13'(ffha_pkg::HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ALLOC_SCAN, S_FREE_DROP, S_COL_MARK,
    S_COL_SWEEP, S_MERGE_LOAD, S_MERGE, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [12:0] heap_bytes;
  logic [3:0]  alloc_limit;

  // chunk and root tables
  logic [11:0] cstart [NC];
  logic [11:0] csize  [NC];
  logic [NC-1:0] cused;
  logic [NC-1:0] cmark;
  logic [CW:0] ccount;
  logic [11:0] roots [NR];
  logic [RW:0] rcount;
  logic [12:0] free_bytes;
  logic [3:0]  live_allocs;
  logic        formatted;

  // command context
  logic [2:0]  kind_q;
  logic [12:0] req_q;
  logic [11:0] off_q;
  logic [CW:0] ix;
  logic [CW-1:0] at_q;
  logic [11:0] cur_size;
  logic        cur_used;
  logic [2:0]  st_q;
  logic [11:0] pay_q;
  logic [3:0]  swept_q;

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {28'd0, alloc_limit} : {19'd0, heap_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes  <= 13'd1024;
      alloc_limit <= 4'd10;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        alloc_limit <= pwdata[3:0];
      end else begin
        heap_bytes <= pwdata[12:0];
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  // Locate: match a payload offset against every chunk start at once.
  logic [11:0] loc_key;
  logic [12:0] loc_key13;
  logic [11:0] loc_tgt;
  logic        loc_hit;
  logic [CW-1:0] loc_ix;
  assign loc_key   = (state == S_COL_MARK) ? roots[ix[RW-1:0]] : off_q;
  assign loc_key13 = {1'b0, loc_key};
  assign loc_tgt   = 12'(loc_key13 - HDR);
  always_comb begin
    loc_hit = 1'b0;
    loc_ix  = '0;
    for (int i = 0; i < NC; i++) begin
      if (!loc_hit && (loc_key13 >= HDR) && ((CW+1)'(i) < ccount) &&
          (cstart[i] == loc_tgt)) begin
        loc_hit = 1'b1;
        loc_ix  = CW'(i);
      end
    end
  end

  // Root match for the free command.
  logic          rhit;
  logic [RW-1:0] rix;
  logic [RW-1:0] rlast;
  assign rlast = RW'(rcount - 1'b1);
  always_comb begin
    rhit = 1'b0;
    rix  = '0;
    for (int i = 0; i < NR; i++) begin
      if (!rhit && ((RW+1)'(i) < rcount) && (roots[i] == off_q)) begin
        rhit = 1'b1;
        rix  = RW'(i);
      end
    end
  end

  // Shared table read port.
  logic [CW:0]   rd_full;
  logic [CW-1:0] rd;
  logic [11:0]   rd_start, rd_size;
  logic          rd_used, rd_mark;
  assign rd_full  = (state == S_MERGE) ? ix + 1'b1 : ix;
  assign rd       = rd_full[CW-1:0];
  assign rd_start = cstart[rd];
  assign rd_size  = csize[rd];
  assign rd_used  = cused[rd];
  assign rd_mark  = cmark[rd];

  // Shared arithmetic.
  logic [13:0] need_split;
  logic        fits, split_ok;
  logic [12:0] total;
  logic [12:0] merged;
  assign need_split = {1'b0, req_q} + 14'(HDR) + 14'd1;
  assign fits       = !rd_used && ({1'b0, rd_size} >= req_q);
  assign split_ok   = ({2'b0, rd_size} >= need_split) && (ccount < (CW+1)'(NC));
  assign total      = (heap_bytes > 13'(ffha_pkg::HEAP_BYTES)) ?
                      13'(ffha_pkg::HEAP_BYTES) : heap_bytes;
  assign merged     = {1'b0, cur_size} + HDR + {1'b0, rd_size};

  logic [3:0] live_dec;
  assign live_dec = (live_allocs != 4'd0) ? live_allocs - 4'd1 : live_allocs;

  // Sequencer, control state and tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cused       <= '0;
      cmark       <= '0;
      ccount      <= '0;
      rcount      <= '0;
      free_bytes  <= '0;
      live_allocs <= '0;
      formatted   <= 1'b0;
      out_valid   <= 1'b0;
      ix          <= '0;
    end else begin
      // drop a transferred result; the finish step loads the next one itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q  <= kind;
            req_q   <= request_bytes;
            off_q   <= block_offset;
            st_q    <= ffha_pkg::ST_OK;
            pay_q   <= '0;
            swept_q <= '0;
            ix      <= '0;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_FINISH;
          case (kind_q)
            ffha_pkg::K_INIT: begin
              if (formatted) begin
                st_q <= ffha_pkg::ST_BUSY;
              end else if (total <= HDR) begin
                st_q <= ffha_pkg::ST_NO_MEM;
              end else begin
                cstart[0]   <= '0;
                csize[0]    <= 12'(total - HDR);
                cused[0]    <= 1'b0;
                cmark[0]    <= 1'b0;
                ccount      <= (CW+1)'(1);
                free_bytes  <= total - HDR;
                live_allocs <= '0;
                formatted   <= 1'b1;
              end
            end
            ffha_pkg::K_ALLOC: begin
              if (live_allocs >= alloc_limit) begin
                st_q <= ffha_pkg::ST_TOO_MANY;
              end else if (req_q == 13'd0) begin
                st_q <= ffha_pkg::ST_BAD_ARG;
              end else if (req_q > free_bytes) begin
                st_q <= ffha_pkg::ST_NO_MEM;
              end else begin
                state <= S_ALLOC_SCAN;
              end
            end
            ffha_pkg::K_FREE: begin
              if (!loc_hit) begin
                st_q <= ffha_pkg::ST_BAD_PTR;
              end else begin
                at_q  <= loc_ix;
                state <= S_FREE_DROP;
              end
            end
            ffha_pkg::K_ROOT: begin
              if (rcount >= (RW+1)'(NR)) begin
                st_q <= ffha_pkg::ST_ROOTS_FULL;
              end else begin
                roots[rcount[RW-1:0]] <= off_q;
                rcount <= rcount + 1'b1;
              end
            end
            ffha_pkg::K_COLLECT: begin
              cmark <= '0;
              state <= S_COL_MARK;
            end
            default: begin
              st_q <= ffha_pkg::ST_BAD_ARG;
            end
          endcase
        end
        S_ALLOC_SCAN: begin
          if (ix >= ccount) begin
            st_q  <= ffha_pkg::ST_NO_MEM;
            state <= S_FINISH;
          end else if (fits) begin
            if (split_ok) begin
              // open a slot after the granted chunk for the tail
              for (int j = 0; j < NC; j++) begin
                if (j >= 2 && (CW+1)'(j) > ix + 1'b1) begin
                  cstart[j] <= cstart[j-1];
                  csize[j]  <= csize[j-1];
                  cused[j]  <= cused[j-1];
                  cmark[j]  <= cmark[j-1];
                end
              end
              cstart[rd+1'b1] <= 12'({1'b0, rd_start} + HDR + req_q);
              csize[rd+1'b1]  <= 12'({1'b0, rd_size} - req_q - HDR);
              cused[rd+1'b1]  <= 1'b0;
              cmark[rd+1'b1]  <= 1'b0;
              ccount          <= ccount + 1'b1;
              csize[rd]       <= req_q[11:0];
              free_bytes      <= free_bytes - req_q;
            end else begin
              free_bytes <= free_bytes - {1'b0, rd_size};
            end
            cused[rd]   <= 1'b1;
            live_allocs <= live_allocs + 4'd1;
            pay_q       <= 12'({1'b0, rd_start} + HDR);
            state       <= S_FINISH;
          end else begin
            ix <= ix + 1'b1;
          end
        end
        S_FREE_DROP: begin
          if (rhit) begin
            roots[rix] <= roots[rlast];
            rcount     <= rcount - 1'b1;
          end
          if (!cused[at_q]) begin
            st_q  <= ffha_pkg::ST_BAD_ARG;
            state <= S_FINISH;
          end else begin
            cused[at_q] <= 1'b0;
            free_bytes  <= free_bytes + {1'b0, csize[at_q]};
            live_allocs <= live_dec;
            ix          <= '0;
            state       <= S_MERGE_LOAD;
          end
        end
        S_COL_MARK: begin
          if (ix >= (CW+1)'(rcount)) begin
            ix    <= '0;
            state <= S_COL_SWEEP;
          end else begin
            if (loc_hit) begin
              cmark[loc_ix] <= 1'b1;
            end
            ix <= ix + 1'b1;
          end
        end
        S_COL_SWEEP: begin
          if (ix >= ccount) begin
            ix    <= '0;
            state <= S_MERGE_LOAD;
          end else begin
            if (rd_used && !rd_mark) begin
              cused[rd]   <= 1'b0;
              free_bytes  <= free_bytes + {1'b0, rd_size};
              live_allocs <= live_dec;
              if (swept_q != 4'd15) begin
                swept_q <= swept_q + 4'd1;
              end
            end
            ix <= ix + 1'b1;
          end
        end
        S_MERGE_LOAD: begin
          cur_size <= rd_size;
          cur_used <= rd_used;
          state    <= S_MERGE;
        end
        S_MERGE: begin
          if (ix + 1'b1 >= ccount) begin
            state <= S_FINISH;
          end else if (!cur_used && !rd_used) begin
            // absorb the next chunk and close its slot
            cur_size  <= merged[11:0];
            csize[ix[CW-1:0]] <= merged[11:0];
            for (int j = 0; j < NC - 1; j++) begin
              if ((CW+1)'(j) > ix) begin
                cstart[j] <= cstart[j+1];
                csize[j]  <= csize[j+1];
                cused[j]  <= cused[j+1];
                cmark[j]  <= cmark[j+1];
              end
            end
            ccount <= ccount - 1'b1;
          end else begin
            cur_size <= rd_size;
            cur_used <= rd_used;
            ix       <= ix + 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            status         <= st_q;
            payload_offset <= pay_q;
            avail_bytes    <= free_bytes;
            live_count     <= live_allocs;
            swept_count    <= swept_q;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/ffha_checker.sv @@
`default_nettype none
`include "first_fit_heap_allocator_with_gc_unit_defines.svh"
module ffha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [11:0] payload_offset,
  input wire logic [3:0]  swept_count
);
  // a waiting result holds
  `FFHA_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped")
  // a command keeps the block busy in the cycle after its transfer
  `FFHA_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after transfer")
  // only a granted alloc reports an offset
  `FFHA_ALWAYS(a_pay_zero, !out_valid || status == ffha_pkg::ST_OK || payload_offset == 12'd0, "offset on failure")
  // sweeping happens only on a successful command
  `FFHA_ALWAYS(a_swept_ok, !out_valid || status == ffha_pkg::ST_OK || swept_count == 4'd0, "sweep on failure")
endmodule

bind first_fit_heap_allocator_with_gc_unit ffha_checker u_ffha_checker (.*);
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] REG_HEAP_BYTES  = 3'h0;
  localparam logic [2:0] REG_ALLOC_LIMIT = 3'h4;

  // Longest command is a collect over a full table; pad it.
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int RANDOM_ITEMS  = 1200;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload_offset;
    logic [12:0] avail_bytes;
    logic [3:0]  live_count;
    logic [3:0]  swept_count;
  } heap_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  kind;
  logic [12:0] request_bytes;
  logic [11:0] block_offset;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [11:0] payload_offset;
  logic [12:0] avail_bytes;
  logic [3:0]  live_count;
  logic [3:0]  swept_count;

  first_fit_heap_allocator_with_gc_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .request_bytes(request_bytes), .block_offset(block_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_offset(payload_offset), .avail_bytes(avail_bytes),
    .live_count(live_count), .swept_count(swept_count)
  );

  // Shadow copy of the allocator: configuration, chunk table, root table.
  int heap_cfg;
  int limit_cfg;
  int seg_start [ffha_pkg::CHUNK_SLOTS];
  int seg_size  [ffha_pkg::CHUNK_SLOTS];
  bit seg_used  [ffha_pkg::CHUNK_SLOTS];
  bit seg_mark  [ffha_pkg::CHUNK_SLOTS];
  int seg_count;
  int root_tab  [ffha_pkg::ROOT_SLOTS];
  int root_cnt;
  int free_cnt;
  int live_cnt;
  bit heap_ready;

  heap_result_t pending_results[$];

  int cycles;
  int mismatches;
  int sent_items;
  int checked_results;
  int swept_total;
  int burst_left;

  // Coverage tallies for the closing summary.
  int status_seen [8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Allocator model
  // ---------------------------------------------------------------------
  function automatic int find_segment(int off);
    for (int i = 0; i < seg_count; i++)
      if (seg_start[i] + ffha_pkg::HEADER_BYTES == off) return i;
    return -1;
  endfunction

  function automatic void drop_segment(int at);
    for (int j = at; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_size[j]  = seg_size[j+1];
      seg_used[j]  = seg_used[j+1];
      seg_mark[j]  = seg_mark[j+1];
    end
    seg_count--;
  endfunction

  // Merge every run of adjacent free chunks into its first chunk.
  function automatic void coalesce();
    int i;
    i = 0;
    while (i + 1 < seg_count) begin
      if (!seg_used[i] && !seg_used[i+1]) begin
        seg_size[i] += ffha_pkg::HEADER_BYTES + seg_size[i+1];
        drop_segment(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  // Swap-remove the first matching root.
  function automatic void unroot(int off);
    for (int i = 0; i < root_cnt; i++)
      if (root_tab[i] == off) begin
        root_tab[i] = root_tab[root_cnt-1];
        root_cnt--;
        return;
      end
  endfunction

  function automatic void release_segment(int i);
    seg_used[i] = 1'b0;
    free_cnt += seg_size[i];
    if (live_cnt > 0) live_cnt--;
  endfunction

  function automatic heap_result_t run_command(logic [2:0] k, int req, int off);
    heap_result_t r;
    int total;
    int at;
    int swept;
    r = '0;
    r.status = ffha_pkg::ST_OK;
    swept = 0;
    case (k)
      ffha_pkg::K_INIT: begin
        total = (heap_cfg > ffha_pkg::HEAP_BYTES) ? ffha_pkg::HEAP_BYTES : heap_cfg;
        if (heap_ready) r.status = ffha_pkg::ST_BUSY;
        else if (total <= ffha_pkg::HEADER_BYTES) r.status = ffha_pkg::ST_NO_MEM;
        else begin
          seg_start[0] = 0;
          seg_size[0]  = total - ffha_pkg::HEADER_BYTES;
          seg_used[0]  = 1'b0;
          seg_mark[0]  = 1'b0;
          seg_count    = 1;
          free_cnt     = seg_size[0];
          live_cnt     = 0;
          heap_ready   = 1'b1;
        end
      end
      ffha_pkg::K_ALLOC: begin
        if (live_cnt >= limit_cfg) r.status = ffha_pkg::ST_TOO_MANY;
        else if (req == 0) r.status = ffha_pkg::ST_BAD_ARG;
        else begin
          r.status = ffha_pkg::ST_NO_MEM;
          if (req <= free_cnt) begin
            for (int i = 0; i < seg_count; i++) begin
              if (seg_used[i] || seg_size[i] < req) continue;
              if (seg_size[i] >= req + ffha_pkg::HEADER_BYTES + 1 &&
                  seg_count < ffha_pkg::CHUNK_SLOTS) begin
                for (int j = seg_count; j > i + 1; j--) begin
                  seg_start[j] = seg_start[j-1];
                  seg_size[j]  = seg_size[j-1];
                  seg_used[j]  = seg_used[j-1];
                  seg_mark[j]  = seg_mark[j-1];
                end
                seg_start[i+1] = seg_start[i] + ffha_pkg::HEADER_BYTES + req;
                seg_size[i+1]  = seg_size[i] - req - ffha_pkg::HEADER_BYTES;
                seg_used[i+1]  = 1'b0;
                seg_mark[i+1]  = 1'b0;
                seg_count++;
                seg_size[i] = req;
              end
              seg_used[i] = 1'b1;
              free_cnt -= seg_size[i];
              live_cnt++;
              r.payload_offset = 12'(seg_start[i] + ffha_pkg::HEADER_BYTES);
              r.status = ffha_pkg::ST_OK;
              break;
            end
          end
        end
      end
      ffha_pkg::K_FREE: begin
        at = find_segment(off);
        if (at < 0) r.status = ffha_pkg::ST_BAD_PTR;
        else begin
          unroot(off);
          if (!seg_used[at]) r.status = ffha_pkg::ST_BAD_ARG;
          else begin
            release_segment(at);
            coalesce();
          end
        end
      end
      ffha_pkg::K_ROOT: begin
        if (root_cnt >= ffha_pkg::ROOT_SLOTS) r.status = ffha_pkg::ST_ROOTS_FULL;
        else begin
          root_tab[root_cnt] = off;
          root_cnt++;
        end
      end
      ffha_pkg::K_COLLECT: begin
        for (int i = 0; i < seg_count; i++) seg_mark[i] = 1'b0;
        for (int i = 0; i < root_cnt; i++) begin
          at = find_segment(root_tab[i]);
          if (at >= 0) seg_mark[at] = 1'b1;
        end
        for (int i = 0; i < seg_count; i++)
          if (seg_used[i] && !seg_mark[i]) begin
            release_segment(i);
            if (swept < 15) swept++;
          end
        coalesce();
      end
      default: r.status = ffha_pkg::ST_BAD_ARG;
    endcase
    r.avail_bytes = free_cnt[12:0];
    r.live_count  = live_cnt[3:0];
    r.swept_count = swept[3:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: compare each output transfer with the oldest prediction
  // ---------------------------------------------------------------------
  int ready_pct;
  int ready_hold;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
      ready_pct  <= 100;
    end else begin
      // Switch the stall pattern every so often; keep some stall-free stretches.
      if (ready_hold == 0) begin
        ready_hold <= $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 75;
          2: ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
      end else begin
        ready_hold <= ready_hold - 1;
      end
      out_ready <= ($urandom_range(1, 100) <= ready_pct);

      if (out_valid && out_ready) begin
        heap_result_t got;
        heap_result_t want;
        got = '{status, payload_offset, avail_bytes, live_count, swept_count};
        if (pending_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("[%0d] result with nothing expected: %p", cycles, got);
        end else begin
          want = pending_results.pop_front();
          checked_results <= checked_results + 1;
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("[%0d] mismatch: expected %p, got %p", cycles, want, got);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] addr, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_HEAP_BYTES) heap_cfg = value & 32'h1FFF;
    else limit_cfg = value & 32'hF;
    // Leave the bus idle before the next access.
    @(posedge clk);
  endtask

  // Transfer one command; valid stays high afterwards while the burst lasts.
  task automatic send_cmd(logic [2:0] k, int req, int off);
    in_valid      <= 1'b1;
    kind          <= k;
    request_bytes <= req[12:0];
    block_offset  <= off[11:0];
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(run_command(k, req, off));
    status_seen[pending_results[$].status]++;
    swept_total += pending_results[$].swept_count;
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  // Hold input idle until every prediction is retired, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int some_payload();
    if (seg_count == 0) return $urandom_range(0, 4095);
    return seg_start[$urandom_range(0, seg_count - 1)] + ffha_pkg::HEADER_BYTES;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_unformatted_heap();
    send_cmd(ffha_pkg::K_COLLECT, 0, 0);
    send_cmd(ffha_pkg::K_ALLOC, 64, 0);
    send_cmd(ffha_pkg::K_FREE, 0, 16);
    send_cmd(ffha_pkg::K_ROOT, 0, 4095);
    send_cmd(3'd7, 8191 & 4096, 4095);
    drain();
  endtask

  task automatic test_format_limits();
    cfg_write(REG_HEAP_BYTES, 0);
    send_cmd(ffha_pkg::K_INIT, 0, 0);
    drain();
    cfg_write(REG_HEAP_BYTES, ffha_pkg::HEADER_BYTES);
    send_cmd(ffha_pkg::K_INIT, 0, 0);
    drain();
    // Oversize setting clamps to the full heap; this is the one real format.
    cfg_write(REG_HEAP_BYTES, 13'h1FFF);
    cfg_write(REG_ALLOC_LIMIT, 15);
    send_cmd(ffha_pkg::K_INIT, 0, 0);
    send_cmd(ffha_pkg::K_INIT, 0, 0);
    drain();
  endtask

  task automatic test_alloc_free_directed();
    int a;
    int b;
    send_cmd(ffha_pkg::K_ALLOC, 0, 0);
    send_cmd(ffha_pkg::K_ALLOC, 4096, 0);
    send_cmd(ffha_pkg::K_ALLOC, 1, 0);
    a = pending_results[$].payload_offset;
    send_cmd(ffha_pkg::K_ALLOC, 100, 0);
    b = pending_results[$].payload_offset;
    send_cmd(ffha_pkg::K_FREE, 0, a + 1);
    send_cmd(ffha_pkg::K_ROOT, 0, b);
    send_cmd(ffha_pkg::K_ROOT, 0, 2);
    send_cmd(ffha_pkg::K_FREE, 0, a);
    send_cmd(ffha_pkg::K_FREE, 0, a);
    send_cmd(ffha_pkg::K_COLLECT, 0, 0);
    send_cmd(ffha_pkg::K_FREE, 0, b);
    send_cmd(ffha_pkg::K_ALLOC, 4096 - 2 * ffha_pkg::HEADER_BYTES - 1, 0);
    send_cmd(ffha_pkg::K_COLLECT, 0, 0);
    send_cmd(3'd5, 0, 0);
    send_cmd(3'd6, 0, 0);
    drain();
    cfg_write(REG_ALLOC_LIMIT, 0);
    send_cmd(ffha_pkg::K_ALLOC, 8, 0);
    drain();
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      case ($urandom_range(0, 9))
        0: send_cmd(ffha_pkg::K_ALLOC, $urandom_range(0, 4096), 0);
        1: send_cmd(ffha_pkg::K_ALLOC, 0, $urandom_range(0, 4095));
        default: send_cmd(ffha_pkg::K_ALLOC, $urandom_range(1, 300), $urandom_range(0, 4095));
      endcase
    end else if (r < 65) begin
      send_cmd(ffha_pkg::K_FREE, $urandom_range(0, 4096),
               ($urandom_range(0, 4) != 0) ? some_payload() : $urandom_range(0, 4095));
    end else if (r < 80) begin
      send_cmd(ffha_pkg::K_ROOT, $urandom_range(0, 4096),
               ($urandom_range(0, 3) != 0) ? some_payload() : $urandom_range(0, 4095));
    end else if (r < 90) begin
      send_cmd(ffha_pkg::K_COLLECT, $urandom_range(0, 4096), $urandom_range(0, 4095));
    end else if (r < 94) begin
      send_cmd(ffha_pkg::K_INIT, $urandom_range(0, 4096), $urandom_range(0, 4095));
    end else begin
      send_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 4096), $urandom_range(0, 4095));
    end
  endtask

  task automatic test_random_traffic();
    int phase_len;
    for (int phase = 0; phase < 6; phase++) begin
      // Revisit both limit extremes among random settings.
      case (phase)
        0: cfg_write(REG_ALLOC_LIMIT, 15);
        1: cfg_write(REG_ALLOC_LIMIT, 1);
        2: cfg_write(REG_ALLOC_LIMIT, 0);
        default: cfg_write(REG_ALLOC_LIMIT, $urandom_range(2, 15));
      endcase
      cfg_write(REG_HEAP_BYTES, $urandom_range(0, 8191));
      phase_len = (phase == 2) ? 40 : (RANDOM_ITEMS - 40) / 5;
      for (int n = 0; n < phase_len; n++) begin
        random_command();
        // Pause mid-phase until the block has answered everything.
        if (n == phase_len / 2) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
  endtask

  task automatic test_root_table_full();
    int fill;
    fill = ffha_pkg::ROOT_SLOTS + 1 - root_cnt;
    for (int n = 0; n < fill; n++) send_cmd(ffha_pkg::K_ROOT, 0, some_payload());
    send_cmd(ffha_pkg::K_COLLECT, 0, 0);
    drain();
  endtask

  initial begin
    cycles          = 0;
    mismatches      = 0;
    sent_items      = 0;
    checked_results = 0;
    swept_total     = 0;
    burst_left      = 0;
    heap_cfg        = 1024;
    limit_cfg       = 10;
    seg_count       = 0;
    root_cnt        = 0;
    free_cnt        = 0;
    live_cnt        = 0;
    heap_ready      = 1'b0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    for (int i = 0; i < ffha_pkg::CHUNK_SLOTS; i++) begin
      seg_used[i] = 1'b0;
      seg_mark[i] = 1'b0;
    end
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= REG_HEAP_BYTES;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    kind          <= ffha_pkg::K_INIT;
    request_bytes <= '0;
    block_offset  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unformatted_heap();
    test_format_limits();
    test_alloc_free_directed();
    test_random_traffic();
    test_root_table_full();

    $display("Covered %0d commands, %0d results checked, %0d chunks swept by collect.",
             sent_items, checked_results, swept_total);
    $display("Status mix ok/badarg/nomem/toomany/busy/badptr/full: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
